// File: hdl/fsp_pkg.sv
// Package for the format spec parser: widths, codes, payload and state types.
package fsp_pkg;

  localparam int INDEX_BITS = 32;
  localparam int WIDTH_BITS = 16;

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;
  localparam logic [7:0] CH_LT       = 8'h3C;
  localparam logic [7:0] CH_GT       = 8'h3E;
  localparam logic [7:0] CH_EQ       = 8'h3D;
  localparam logic [7:0] CH_CARET    = 8'h5E;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_LBRACK   = 8'h5B;
  localparam logic [7:0] CH_RBRACK   = 8'h5D;
  localparam logic [7:0] CH_BANG     = 8'h21;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_HASH     = 8'h23;
  localparam logic [7:0] FILL_DEFAULT = CH_PRINT_LO;

  localparam logic [1:0] KIND_FIRST = 2'd0;
  localparam logic [1:0] KIND_NEXT  = 2'd1;
  localparam logic [1:0] KIND_INDEX = 2'd2;
  localparam logic [1:0] KIND_FINAL = 2'd3;

  localparam logic [1:0] CONV_NONE = 2'd0;
  localparam logic [1:0] CONV_STR  = 2'd1;
  localparam logic [1:0] CONV_REPR = 2'd2;

  localparam logic [2:0] ALIGN_NONE   = 3'd0;
  localparam logic [2:0] ALIGN_LEFT   = 3'd1;
  localparam logic [2:0] ALIGN_RIGHT  = 3'd2;
  localparam logic [2:0] ALIGN_NUMBER = 3'd3;
  localparam logic [2:0] ALIGN_CENTER = 3'd4;

  localparam logic [1:0] SIGN_NONE  = 2'd0;
  localparam logic [1:0] SIGN_PLUS  = 2'd1;
  localparam logic [1:0] SIGN_MINUS = 2'd2;
  localparam logic [1:0] SIGN_SPACE = 2'd3;

  localparam logic [1:0] GROUP_NONE  = 2'd0;
  localparam logic [1:0] GROUP_COMMA = 2'd1;
  localparam logic [1:0] GROUP_UNDER = 2'd2;

  localparam logic [3:0] TYPE_NONE  = 4'd0;
  localparam logic [3:0] TYPE_B     = 4'd1;
  localparam logic [3:0] TYPE_C     = 4'd2;
  localparam logic [3:0] TYPE_D     = 4'd3;
  localparam logic [3:0] TYPE_O     = 4'd4;
  localparam logic [3:0] TYPE_X     = 4'd5;
  localparam logic [3:0] TYPE_XUP   = 4'd6;
  localparam logic [3:0] TYPE_N     = 4'd7;
  localparam logic [3:0] TYPE_S     = 4'd8;

  typedef enum logic [14:0] {
    PH_ACC      = 15'h0001,
    PH_NAME     = 15'h0002,
    PH_IDX0     = 15'h0004,
    PH_IDX      = 15'h0008,
    PH_CONV     = 15'h0010,
    PH_POSTCONV = 15'h0020,
    PH_FILL0    = 15'h0040,
    PH_FILL1    = 15'h0080,
    PH_SIGN     = 15'h0100,
    PH_ALT      = 15'h0200,
    PH_WIDTH    = 15'h0400,
    PH_WDIG     = 15'h0800,
    PH_GROUP    = 15'h1000,
    PH_TYPE     = 15'h2000,
    PH_DONE     = 15'h4000
  } phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  char_value;
    logic [31:0] index_value;
    logic        ok;
    logic [1:0]  conversion;
    logic        fill_given;
    logic [2:0]  align;
    logic [1:0]  sign_mode;
    logic        alternate;
    logic [15:0] field_width;
    logic [1:0]  grouping;
    logic [3:0]  spec_type;
  } out_item_t;

  typedef struct packed {
    logic      a_valid;
    out_item_t a;
    logic      b_valid;
    out_item_t b;
  } res_pair_t;

  typedef struct packed {
    logic [1:0] conversion;
    logic       fill_given;
    logic [7:0] fill_char;
    logic [2:0] align;
    logic [1:0] sign_mode;
    logic       alternate;
    logic [1:0] grouping;
    logic [3:0] spec_type;
  } spec_t;

  typedef struct packed {
    phase_t                  phase;
    logic [7:0]              pend;
    logic [INDEX_BITS-1:0]   idx;
    logic [WIDTH_BITS-1:0]   wid;
    logic                    in_name;
    logic                    err;
    spec_t                   spec;
  } pstate_t;

endpackage

// File: hdl/fsp_parse.sv
// Parser state registers and the per-character next-state and result decode.
module fsp_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  fsp_pkg::in_item_t  in_data,
  output fsp_pkg::res_pair_t res
);

  localparam int IB = fsp_pkg::INDEX_BITS;
  localparam int WB = fsp_pkg::WIDTH_BITS;

  fsp_pkg::pstate_t st_r, st_nxt, st_rst;

  function automatic logic is_dec_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic [2:0] align_code(logic [7:0] c);
    logic [2:0] a;
    a = fsp_pkg::ALIGN_NONE;
    if (c == fsp_pkg::CH_LT) a = fsp_pkg::ALIGN_LEFT;
    else if (c == fsp_pkg::CH_GT) a = fsp_pkg::ALIGN_RIGHT;
    else if (c == fsp_pkg::CH_EQ) a = fsp_pkg::ALIGN_NUMBER;
    else if (c == fsp_pkg::CH_CARET) a = fsp_pkg::ALIGN_CENTER;
    return a;
  endfunction

  function automatic logic [3:0] type_code(logic [7:0] c);
    logic [3:0] t;
    t = fsp_pkg::TYPE_NONE;
    if (c == "b") t = fsp_pkg::TYPE_B;
    else if (c == "c") t = fsp_pkg::TYPE_C;
    else if (c == "d") t = fsp_pkg::TYPE_D;
    else if (c == "o") t = fsp_pkg::TYPE_O;
    else if (c == "x") t = fsp_pkg::TYPE_X;
    else if (c == "X") t = fsp_pkg::TYPE_XUP;
    else if (c == "n") t = fsp_pkg::TYPE_N;
    else if (c == "s") t = fsp_pkg::TYPE_S;
    return t;
  endfunction

  // sign, '#', width, grouping, type, each part optional and in order
  function automatic fsp_pkg::pstate_t spec_char(fsp_pkg::pstate_t s_in, logic [7:0] c);
    fsp_pkg::pstate_t s;
    logic             done;
    logic [WB+3:0]    wsum;
    logic [3:0]       tc;
    s    = s_in;
    done = 1'b0;
    wsum = '0;
    tc   = type_code(c);
    if (!s.err) begin
      if (s.phase == fsp_pkg::PH_SIGN) begin
        s.phase = fsp_pkg::PH_ALT;
        if (c == "+") begin
          s.spec.sign_mode = fsp_pkg::SIGN_PLUS;
          done = 1'b1;
        end else if (c == "-") begin
          s.spec.sign_mode = fsp_pkg::SIGN_MINUS;
          done = 1'b1;
        end else if (c == " ") begin
          s.spec.sign_mode = fsp_pkg::SIGN_SPACE;
          done = 1'b1;
        end
      end
      if (!done && s.phase == fsp_pkg::PH_ALT) begin
        s.phase = fsp_pkg::PH_WIDTH;
        if (c == fsp_pkg::CH_HASH) begin
          s.spec.alternate = 1'b1;
          done = 1'b1;
        end
      end
      if (!done && s.phase == fsp_pkg::PH_WIDTH) begin
        if (is_dec_digit(c)) begin
          s.wid   = WB'(c[3:0]);
          s.phase = fsp_pkg::PH_WDIG;
          done    = 1'b1;
        end else begin
          s.phase = fsp_pkg::PH_GROUP;
        end
      end
      if (!done && s.phase == fsp_pkg::PH_WDIG) begin
        if (is_dec_digit(c)) begin
          wsum = ({4'b0, s.wid} << 3) + ({4'b0, s.wid} << 1) + (WB+4)'(c[3:0]);
          if (|wsum[WB+3:WB]) s.err = 1'b1;
          else s.wid = wsum[WB-1:0];
          done = 1'b1;
        end else begin
          s.phase = fsp_pkg::PH_GROUP;
        end
      end
      if (!done && s.phase == fsp_pkg::PH_GROUP) begin
        s.phase = fsp_pkg::PH_TYPE;
        if (c == ",") begin
          s.spec.grouping = fsp_pkg::GROUP_COMMA;
          done = 1'b1;
        end else if (c == "_") begin
          s.spec.grouping = fsp_pkg::GROUP_UNDER;
          done = 1'b1;
        end
      end
      if (!done && s.phase == fsp_pkg::PH_TYPE) begin
        s.phase = fsp_pkg::PH_DONE;
        if (tc != fsp_pkg::TYPE_NONE) begin
          s.spec.spec_type = tc;
          done = 1'b1;
        end
      end
      if (!done) s.err = 1'b1;
    end
    return s;
  endfunction

  fsp_pkg::pstate_t s;
  logic             has;
  logic [7:0]       c;
  logic [IB-1:0]    ibase;
  logic [IB+3:0]    isum;
  logic [2:0]       a0, a1;

  always_comb begin
    st_rst       = '0;
    st_rst.phase = fsp_pkg::PH_ACC;
  end

  always_comb begin
    s     = st_r;
    c     = in_data.ch;
    has   = in_data.has_char;
    res   = '0;
    ibase = '0;
    isum  = '0;
    a0    = align_code(st_r.pend);
    a1    = align_code(c);

    if (has && !s.err) begin
      if (s.phase == fsp_pkg::PH_NAME) begin
        if (((c >= "a") && (c <= "z")) || (c == "_")) begin
          res.a_valid      = 1'b1;
          res.a.kind       = s.in_name ? fsp_pkg::KIND_NEXT : fsp_pkg::KIND_FIRST;
          res.a.char_value = c;
          s.in_name        = 1'b1;
          has              = 1'b0;
        end else if (!s.in_name) begin
          s.err = 1'b1;
        end else begin
          s.in_name = 1'b0;
          s.phase   = fsp_pkg::PH_ACC;
        end
      end
      if (has && !s.err) begin
        unique case (s.phase)
          fsp_pkg::PH_ACC: begin
            if (c == fsp_pkg::CH_DOT) begin
              s.phase   = fsp_pkg::PH_NAME;
              s.in_name = 1'b0;
            end else if (c == fsp_pkg::CH_LBRACK) begin
              s.phase = fsp_pkg::PH_IDX0;
              s.idx   = '0;
            end else if (c == fsp_pkg::CH_BANG) begin
              s.phase = fsp_pkg::PH_CONV;
            end else if (c == fsp_pkg::CH_COLON) begin
              s.phase = fsp_pkg::PH_FILL0;
            end else begin
              s.err = 1'b1;
            end
          end
          fsp_pkg::PH_IDX0, fsp_pkg::PH_IDX: begin
            if (is_dec_digit(c)) begin
              ibase = (s.phase == fsp_pkg::PH_IDX0) ? '0 : s.idx;
              isum  = ({4'b0, ibase} << 3) + ({4'b0, ibase} << 1) + (IB+4)'(c[3:0]);
              if (|isum[IB+3:IB]) s.err = 1'b1;
              else s.idx = isum[IB-1:0];
              s.phase = fsp_pkg::PH_IDX;
            end else if (c == fsp_pkg::CH_RBRACK && s.phase == fsp_pkg::PH_IDX) begin
              res.a_valid       = 1'b1;
              res.a.kind        = fsp_pkg::KIND_INDEX;
              res.a.index_value = 32'(s.idx);
              s.idx             = '0;
              s.phase           = fsp_pkg::PH_ACC;
            end else begin
              s.err = 1'b1;
            end
          end
          fsp_pkg::PH_CONV: begin
            if (c == "s") begin
              s.spec.conversion = fsp_pkg::CONV_STR;
              s.phase           = fsp_pkg::PH_POSTCONV;
            end else if (c == "r") begin
              s.spec.conversion = fsp_pkg::CONV_REPR;
              s.phase           = fsp_pkg::PH_POSTCONV;
            end else begin
              s.err = 1'b1;
            end
          end
          fsp_pkg::PH_POSTCONV: begin
            if (c == fsp_pkg::CH_COLON) s.phase = fsp_pkg::PH_FILL0;
            else s.err = 1'b1;
          end
          fsp_pkg::PH_FILL0: begin
            s.pend  = c;
            s.phase = fsp_pkg::PH_FILL1;
          end
          fsp_pkg::PH_FILL1: begin
            s.phase = fsp_pkg::PH_SIGN;
            if (a1 != fsp_pkg::ALIGN_NONE) begin
              if (s.pend < fsp_pkg::CH_PRINT_LO || s.pend > fsp_pkg::CH_PRINT_HI) begin
                s.err = 1'b1;
              end else begin
                s.spec.fill_given = 1'b1;
                s.spec.fill_char  = s.pend;
                s.spec.align      = a1;
              end
            end else if (a0 != fsp_pkg::ALIGN_NONE) begin
              s.spec.align = a0;
              s = spec_char(s, c);
            end else begin
              s = spec_char(spec_char(s, s.pend), c);
            end
            s.pend = '0;
          end
          default: begin
            s = spec_char(s, c);
          end
        endcase
      end
    end

    if (in_data.last) begin
      if (!s.err) begin
        if (s.phase == fsp_pkg::PH_NAME && !s.in_name) begin
          s.err = 1'b1;
        end else if (s.phase == fsp_pkg::PH_IDX0 || s.phase == fsp_pkg::PH_IDX ||
                     s.phase == fsp_pkg::PH_CONV) begin
          s.err = 1'b1;
        end else if (s.phase == fsp_pkg::PH_FILL1) begin
          s.phase = fsp_pkg::PH_SIGN;
          if (align_code(s.pend) != fsp_pkg::ALIGN_NONE) s.spec.align = align_code(s.pend);
          else s = spec_char(s, s.pend);
        end
      end
      res.b_valid = 1'b1;
      res.b.kind  = fsp_pkg::KIND_FINAL;
      if (!s.err) begin
        res.b.char_value  = s.spec.fill_given ? s.spec.fill_char : fsp_pkg::FILL_DEFAULT;
        res.b.ok          = 1'b1;
        res.b.conversion  = s.spec.conversion;
        res.b.fill_given  = s.spec.fill_given;
        res.b.align       = s.spec.align;
        res.b.sign_mode   = s.spec.sign_mode;
        res.b.alternate   = s.spec.alternate;
        res.b.field_width = 16'(s.wid);
        res.b.grouping    = s.spec.grouping;
        res.b.spec_type   = s.spec.spec_type;
      end
      st_nxt = st_rst;
    end else begin
      st_nxt = s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= st_rst;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

endmodule

// File: hdl/fsp_outq.sv
// Result queue: takes up to two results per transfer, hands out one per cycle while out_ready is high.
module fsp_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  fsp_pkg::res_pair_t  res,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output fsp_pkg::out_item_t  out_data
);

  localparam int PW = fsp_pkg::OUTQ_PTR_W;
  localparam int CW = fsp_pkg::OUTQ_CNT_W;

  fsp_pkg::out_item_t mem_r [fsp_pkg::OUTQ_DEPTH];
  logic [PW-1:0] head_r, head_nxt, tail_r, tail_nxt, tail_b;
  logic [CW-1:0] count_r, count_nxt;
  logic          push_a, push_b, pop;
  logic [1:0]    push_n;

  assign push_a    = accept && res.a_valid;
  assign push_b    = accept && res.b_valid;
  assign push_n    = {1'b0, push_a} + {1'b0, push_b};
  assign out_valid = (count_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = mem_r[head_r];
  assign in_ready  = (count_r <= CW'(fsp_pkg::OUTQ_DEPTH - 2));
  assign tail_b    = push_a ? PW'(tail_r + 1'b1) : tail_r;

  always_comb begin
    head_nxt  = pop ? PW'(head_r + 1'b1) : head_r;
    tail_nxt  = PW'(tail_r + PW'(push_n));
    count_nxt = CW'(count_r + CW'(push_n) - CW'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) mem_r[tail_r] <= res.a;
    if (push_b) mem_r[tail_b] <= res.b;
  end

endmodule

// File: hdl/format_spec_parser.sv
// Top level of the format spec parser: handshake, parser and result queue.
// One character is taken per cycle while in_ready is high; its results go
// into the result queue on the transfer. A name character or an index gives
// one result, the last item adds the final spec result; an item with two
// results sends them in turn. Results wait in a four-entry queue, and in_ready
// is high while the queue has room for two more, so input keeps flowing at
// one item per cycle as long as the output side drains one result per cycle.
module format_spec_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fsp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fsp_pkg::out_item_t out_data
);

  logic               accept;
  fsp_pkg::res_pair_t res;

  assign accept = in_valid && in_ready;

  fsp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .res     (res)
  );

  fsp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .res       (res),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: hdl/fsp_checker.sv
// Port-level assertions for the format spec parser, bound to the top level.
module fsp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input fsp_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present right after reset");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == fsp_pkg::KIND_FINAL && !out_data.ok |->
      out_data.char_value == 8'd0 && out_data.field_width == 16'd0 &&
      out_data.align == fsp_pkg::ALIGN_NONE && out_data.spec_type == fsp_pkg::TYPE_NONE &&
      !out_data.fill_given && out_data.conversion == fsp_pkg::CONV_NONE)
    else $error("failed final carries nonzero fields");

  a_accessor_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != fsp_pkg::KIND_FINAL |->
      !out_data.ok && out_data.field_width == 16'd0 &&
      out_data.spec_type == fsp_pkg::TYPE_NONE && !out_data.fill_given)
    else $error("accessor result carries spec fields");

  a_default_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == fsp_pkg::KIND_FINAL && out_data.ok &&
      !out_data.fill_given |-> out_data.char_value == fsp_pkg::FILL_DEFAULT)
    else $error("default fill is not a space");

endmodule

bind format_spec_parser fsp_checker u_fsp_checker (.*);

// File: sim/format_spec_parser_test.sv
// Testbench for format_spec_parser: random format strings checked against a behavioral parser.
`timescale 1ns / 1ps

module format_spec_parser_test;
  import fsp_pkg::*;

  typedef logic [7:0] text_t[$];

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [63:0] INDEX_MAX = (64'd1 << INDEX_BITS) - 64'd1;
  localparam logic [63:0] WIDTH_MAX = (64'd1 << WIDTH_BITS) - 64'd1;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  format_spec_parser uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  in_item_t  format_bytes[$];
  out_item_t parse_results[$];
  int        stim_items = 0;
  int        mismatches = 0;
  int        result_count = 0;
  int        cycles = 0;
  int        in_wait = 0;
  int        out_wait = 0;
  bit        in_calm = 1'b0;
  bit        out_calm = 1'b0;
  // transfer seen at the last rising edge, per side
  logic      in_taken = 1'b0;
  logic      out_taken = 1'b0;

  phase_t      ps_phase;
  logic [7:0]  ps_held;
  logic [63:0] ps_idx;
  logic [63:0] ps_wid;
  logic        ps_in_name;
  logic        ps_err;
  logic [1:0]  ps_conv;
  logic        ps_fill_given;
  logic [7:0]  ps_fill;
  logic [2:0]  ps_align;
  logic [1:0]  ps_sign;
  logic        ps_alt;
  logic [1:0]  ps_group;
  logic [3:0]  ps_type;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void clear_parse_state();
    ps_phase = PH_ACC;
    ps_held = '0;
    ps_idx = '0;
    ps_wid = '0;
    ps_in_name = 1'b0;
    ps_err = 1'b0;
    ps_conv = CONV_NONE;
    ps_fill_given = 1'b0;
    ps_fill = '0;
    ps_align = ALIGN_NONE;
    ps_sign = SIGN_NONE;
    ps_alt = 1'b0;
    ps_group = GROUP_NONE;
    ps_type = TYPE_NONE;
  endfunction

  function automatic bit is_dec_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [2:0] align_of(logic [7:0] c);
    case (c)
      CH_LT:    return ALIGN_LEFT;
      CH_GT:    return ALIGN_RIGHT;
      CH_EQ:    return ALIGN_NUMBER;
      CH_CARET: return ALIGN_CENTER;
      default:  return ALIGN_NONE;
    endcase
  endfunction

  function automatic bit add_digit(inout logic [63:0] acc, input logic [7:0] c,
                                   input logic [63:0] top);
    logic [63:0] d;
    d = 64'(c - "0");
    if (acc > (top - d) / 64'd10) return 1'b0;
    acc = acc * 64'd10 + d;
    return 1'b1;
  endfunction

  function automatic void spec_byte(logic [7:0] c);
    if (ps_err) return;
    if (ps_phase == PH_SIGN) begin
      ps_phase = PH_ALT;
      if (c == "+") begin ps_sign = SIGN_PLUS; return; end
      if (c == "-") begin ps_sign = SIGN_MINUS; return; end
      if (c == " ") begin ps_sign = SIGN_SPACE; return; end
    end
    if (ps_phase == PH_ALT) begin
      ps_phase = PH_WIDTH;
      if (c == CH_HASH) begin ps_alt = 1'b1; return; end
    end
    if (ps_phase == PH_WIDTH) begin
      if (is_dec_digit(c)) begin
        ps_wid = 64'(c - "0");
        ps_phase = PH_WDIG;
        return;
      end
      ps_phase = PH_GROUP;
    end
    if (ps_phase == PH_WDIG) begin
      if (is_dec_digit(c)) begin
        if (!add_digit(ps_wid, c, WIDTH_MAX)) ps_err = 1'b1;
        return;
      end
      ps_phase = PH_GROUP;
    end
    if (ps_phase == PH_GROUP) begin
      ps_phase = PH_TYPE;
      if (c == ",") begin ps_group = GROUP_COMMA; return; end
      if (c == "_") begin ps_group = GROUP_UNDER; return; end
    end
    if (ps_phase == PH_TYPE) begin
      ps_phase = PH_DONE;
      case (c)
        "b":     ps_type = TYPE_B;
        "c":     ps_type = TYPE_C;
        "d":     ps_type = TYPE_D;
        "o":     ps_type = TYPE_O;
        "x":     ps_type = TYPE_X;
        "X":     ps_type = TYPE_XUP;
        "n":     ps_type = TYPE_N;
        "s":     ps_type = TYPE_S;
        default: ps_type = TYPE_NONE;
      endcase
      if (ps_type != TYPE_NONE) return;
    end
    ps_err = 1'b1;
  endfunction

  function automatic void parse_byte(in_item_t it);
    logic [7:0] c;
    bit         has;
    logic [2:0] a_now;
    logic [2:0] a_held;
    out_item_t  r;
    c = it.ch;
    has = it.has_char;
    if (has && !ps_err) begin
      if (ps_phase == PH_NAME) begin
        if ((c >= "a" && c <= "z") || c == "_") begin
          r = '0;
          r.kind = ps_in_name ? KIND_NEXT : KIND_FIRST;
          r.char_value = c;
          parse_results.push_back(r);
          ps_in_name = 1'b1;
          has = 1'b0;
        end else if (!ps_in_name) begin
          ps_err = 1'b1;
        end else begin
          ps_in_name = 1'b0;
          ps_phase = PH_ACC;
        end
      end
      if (has && !ps_err) begin
        case (ps_phase)
          PH_ACC: begin
            if (c == CH_DOT) begin
              ps_phase = PH_NAME;
              ps_in_name = 1'b0;
            end else if (c == CH_LBRACK) begin
              ps_phase = PH_IDX0;
              ps_idx = '0;
            end else if (c == CH_BANG) begin
              ps_phase = PH_CONV;
            end else if (c == CH_COLON) begin
              ps_phase = PH_FILL0;
            end else begin
              ps_err = 1'b1;
            end
          end
          PH_IDX0, PH_IDX: begin
            if (is_dec_digit(c)) begin
              if (ps_phase == PH_IDX0) ps_idx = '0;
              if (!add_digit(ps_idx, c, INDEX_MAX)) ps_err = 1'b1;
              ps_phase = PH_IDX;
            end else if (c == CH_RBRACK && ps_phase == PH_IDX) begin
              r = '0;
              r.kind = KIND_INDEX;
              r.index_value = ps_idx[31:0];
              parse_results.push_back(r);
              ps_idx = '0;
              ps_phase = PH_ACC;
            end else begin
              ps_err = 1'b1;
            end
          end
          PH_CONV: begin
            if (c == "s") begin
              ps_conv = CONV_STR;
              ps_phase = PH_POSTCONV;
            end else if (c == "r") begin
              ps_conv = CONV_REPR;
              ps_phase = PH_POSTCONV;
            end else begin
              ps_err = 1'b1;
            end
          end
          PH_POSTCONV: begin
            if (c == CH_COLON) ps_phase = PH_FILL0;
            else ps_err = 1'b1;
          end
          PH_FILL0: begin
            ps_held = c;
            ps_phase = PH_FILL1;
          end
          PH_FILL1: begin
            a_now = align_of(c);
            a_held = align_of(ps_held);
            ps_phase = PH_SIGN;
            if (a_now != ALIGN_NONE) begin
              if (ps_held < CH_PRINT_LO || ps_held > CH_PRINT_HI) begin
                ps_err = 1'b1;
              end else begin
                ps_fill_given = 1'b1;
                ps_fill = ps_held;
                ps_align = a_now;
              end
            end else if (a_held != ALIGN_NONE) begin
              ps_align = a_held;
              spec_byte(c);
            end else begin
              spec_byte(ps_held);
              spec_byte(c);
            end
            ps_held = '0;
          end
          default: spec_byte(c);
        endcase
      end
    end
    if (it.last) begin
      if (!ps_err) begin
        if (ps_phase == PH_NAME && !ps_in_name) begin
          ps_err = 1'b1;
        end else if (ps_phase == PH_IDX0 || ps_phase == PH_IDX || ps_phase == PH_CONV) begin
          ps_err = 1'b1;
        end else if (ps_phase == PH_FILL1) begin
          a_held = align_of(ps_held);
          ps_phase = PH_SIGN;
          if (a_held != ALIGN_NONE) ps_align = a_held;
          else spec_byte(ps_held);
        end
      end
      r = '0;
      r.kind = KIND_FINAL;
      if (!ps_err) begin
        r.char_value = ps_fill_given ? ps_fill : FILL_DEFAULT;
        r.ok = 1'b1;
        r.conversion = ps_conv;
        r.fill_given = ps_fill_given;
        r.align = ps_align;
        r.sign_mode = ps_sign;
        r.alternate = ps_alt;
        r.field_width = ps_wid[15:0];
        r.grouping = ps_group;
        r.spec_type = ps_type;
      end
      parse_results.push_back(r);
      clear_parse_state();
    end
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      note_mismatch($sformatf("result %0d %s = 0x%0h, want 0x%0h", result_count, name, got, want));
  endtask

  task automatic check_result(out_item_t got, out_item_t want);
    check_field("kind", got.kind, want.kind);
    check_field("char_value", got.char_value, want.char_value);
    check_field("index_value", got.index_value, want.index_value);
    check_field("ok", got.ok, want.ok);
    check_field("conversion", got.conversion, want.conversion);
    check_field("fill_given", got.fill_given, want.fill_given);
    check_field("align", got.align, want.align);
    check_field("sign_mode", got.sign_mode, want.sign_mode);
    check_field("alternate", got.alternate, want.alternate);
    check_field("field_width", got.field_width, want.field_width);
    check_field("grouping", got.grouping, want.grouping);
    check_field("spec_type", got.spec_type, want.spec_type);
  endtask

  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 47) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic void put_text(ref text_t t, input string s);
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
  endfunction

  function automatic void put_number(ref text_t t, input int bits);
    logic [63:0] top;
    logic [63:0] v;
    top = (64'd1 << bits) - 64'd1;
    case ($urandom_range(0, 11))
      0:       v = top;
      1:       v = top + 64'd1;
      2:       v = {$urandom, $urandom};
      default: v = 64'($urandom_range(0, 999));
    endcase
    if ($urandom_range(0, 7) == 0) t.push_back("0");
    put_text(t, $sformatf("%0d", v));
  endfunction

  task automatic send_text(input text_t t, input bit empty_tail);
    in_item_t it;
    for (int i = 0; i < t.size(); i++) begin
      if ($urandom_range(0, 15) == 0) begin
        it.ch = 8'($urandom);
        it.has_char = 1'b0;
        it.last = 1'b0;
        format_bytes.push_back(it);
      end
      it.ch = t[i];
      it.has_char = 1'b1;
      it.last = (i == t.size() - 1) && !empty_tail;
      format_bytes.push_back(it);
      stim_items++;
    end
    if (empty_tail || t.size() == 0) begin
      it.ch = 8'($urandom);
      it.has_char = 1'b0;
      it.last = 1'b1;
      format_bytes.push_back(it);
      stim_items++;
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (in_taken) in_wait = draw_wait(in_calm);
        if (in_wait > 0) begin
          in_valid <= 1'b0;
          in_wait--;
        end else if (format_bytes.size() > 0) begin
          in_data <= format_bytes.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_taken) out_wait = draw_wait(out_calm);
      if (out_wait > 0) begin
        out_ready <= 1'b0;
        out_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else if (!rst_n) begin
      clear_parse_state();
      in_taken <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      out_taken <= out_valid && out_ready;
      if (in_valid && in_ready) parse_byte(in_data);
      if (out_valid && out_ready) begin
        if (parse_results.size() == 0) begin
          note_mismatch($sformatf("result %0d arrived with none pending", result_count));
        end else begin
          check_result(out_data, parse_results.pop_front());
        end
        result_count++;
      end
    end
  end

  initial begin
    text_t      t;
    int         sel;
    logic [7:0] a;
    string      pool;
    string      letters;
    string      signs;
    pool = ".[]!:#<>=^+- ,_0123456789abcdnorsxX";
    letters = "bcdoxXns";
    signs = " +-";

    t = {};
    send_text(t, 1'b0);
    t = {CH_COLON, 8'h01, CH_LT};
    send_text(t, 1'b0);
    t = {};
    put_text(t, ":65536");
    send_text(t, 1'b0);
    t = {};
    put_text(t, "x.a");
    send_text(t, 1'b0);
    t = {};
    put_text(t, ".a_[7]!r:=+#9_X");
    send_text(t, 1'b0);

    while (stim_items < 1650) begin
      t = {};
      sel = $urandom_range(0, 19);
      if (sel < 3) begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 1)) t.push_back(8'($urandom));
          else t.push_back(pool[$urandom_range(0, pool.len() - 1)]);
        end
      end else begin
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(0, 1)) begin
            t.push_back(CH_DOT);
            repeat ($urandom_range(1, 4)) begin
              if ($urandom_range(0, 8) == 0) t.push_back("_");
              else t.push_back(8'("a" + $urandom_range(0, 25)));
            end
          end else begin
            t.push_back(CH_LBRACK);
            put_number(t, INDEX_BITS);
            t.push_back(CH_RBRACK);
          end
        end
        if ($urandom_range(0, 2) == 0) begin
          t.push_back(CH_BANG);
          t.push_back($urandom_range(0, 1) ? "s" : "r");
        end
        if ($urandom_range(0, 3) != 0) begin
          t.push_back(CH_COLON);
          case ($urandom_range(0, 3))
            0: a = CH_LT;
            1: a = CH_GT;
            2: a = CH_EQ;
            default: a = CH_CARET;
          endcase
          case ($urandom_range(0, 2))
            1: t.push_back(a);
            2: begin
              if ($urandom_range(0, 9) == 0) t.push_back(8'($urandom));
              else t.push_back(8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)));
              t.push_back(a);
            end
            default: ;
          endcase
          if ($urandom_range(0, 1)) t.push_back(signs[$urandom_range(0, 2)]);
          if ($urandom_range(0, 2) == 0) t.push_back(CH_HASH);
          if ($urandom_range(0, 1)) put_number(t, WIDTH_BITS);
          if ($urandom_range(0, 2) == 0) t.push_back($urandom_range(0, 1) ? "," : "_");
          if ($urandom_range(0, 1)) t.push_back(letters[$urandom_range(0, 7)]);
        end
        if (sel < 6) begin
          if (t.size() == 0) begin
            t.push_back(8'($urandom));
          end else begin
            case ($urandom_range(0, 2))
              0: t.insert($urandom_range(0, t.size()), 8'($urandom));
              1: t.delete($urandom_range(0, t.size() - 1));
              default: begin
                sel = $urandom_range(0, t.size() - 1);
                while (t.size() > sel) void'(t.pop_back());
              end
            endcase
          end
        end
      end
      send_text(t, $urandom_range(0, 7) == 0);
    end

    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    while (format_bytes.size() != 0 || in_valid || parse_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
